[hdl/bbrs_pkg.sv]
`default_nettype none
package bbrs_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int RADIUS_MAX = 7;
  localparam int KERNEL_MAX = 2 * RADIUS_MAX + 1;

  localparam int PIX_W    = 8;
  localparam int NUM_CH   = 3;
  localparam int LW_W     = 11;
  localparam int HGT_W    = 16;
  localparam int RAD_W    = 3;
  localparam int ROW_W    = HGT_W + 1;
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int K_W      = $clog2(KERNEL_MAX + 1);
  localparam int SLOT_W   = $clog2(KERNEL_MAX);
  localparam int TAIL_W   = $clog2(RADIUS_MAX + 1);
  localparam int LS_DEPTH = KERNEL_MAX * MAX_WIDTH;
  localparam int LS_AW    = $clog2(LS_DEPTH);
  localparam int CS_W     = $clog2(KERNEL_MAX * 255 + 1);
  localparam int WS_W     = $clog2(KERNEL_MAX * KERNEL_MAX * 255 + 1);
  localparam int CNT_W    = $clog2(KERNEL_MAX * KERNEL_MAX + 1);
  localparam int FRAC_BITS = 24;
  localparam int SCALE_W  = FRAC_BITS + 1;
  localparam int PROD_W   = WS_W + SCALE_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BLUR_RADIUS  = CFG_IDX_W'(2);

  localparam logic [LW_W-1:0]  LINE_WIDTH_RESET   = LW_W'(1024);
  localparam logic [HGT_W-1:0] IMAGE_HEIGHT_RESET = HGT_W'(1024);
  localparam logic [RAD_W-1:0] BLUR_RADIUS_RESET  = RAD_W'(1);

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

  typedef struct packed {
    logic               take;
    logic               rd;
    logic [LS_AW-1:0]   ls_addr;
    logic [COL_W-1:0]   cs_raddr;
    logic               upd;
    logic               drain;
    logic               sub_en;
    logic               win_clr;
    logic               win_en;
    logic [COL_W-1:0]   cs_waddr;
    logic               ws_sub;
    logic               clr;
    logic               emit;
    logic               approx;
    logic [CNT_W-1:0]   count;
    logic [SCALE_W-1:0] scale;
    logic               last;
    logic               eoi;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_stat_t;

  function automatic logic [SCALE_W-1:0] scale_for_radius(input logic [RAD_W-1:0] r);
    case (r)
      3'd0:    return SCALE_W'(16777216);
      3'd1:    return SCALE_W'(1864135);
      3'd2:    return SCALE_W'(671088);
      3'd3:    return SCALE_W'(342392);
      3'd4:    return SCALE_W'(207126);
      3'd5:    return SCALE_W'(138654);
      3'd6:    return SCALE_W'(99273);
      3'd7:    return SCALE_W'(74565);
      default: return '0;
    endcase
  endfunction

endpackage
`default_nettype wire

[hdl/bbrs_ifs.sv]
`default_nettype none
interface bbrs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       is_flush;
  modport source (output valid, red_in, green_in, blue_in, is_flush, input ready);
  modport sink (input valid, red_in, green_in, blue_in, is_flush, output ready);
endinterface

interface bbrs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       last_in_run;
  logic       end_of_image;
  modport source (output valid, red_out, green_out, blue_out, alpha_out, last_in_run,
                  end_of_image, input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, last_in_run,
                end_of_image, output ready);
endinterface

interface bbrs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/bbrs_ram.sv]
`default_nettype none
module bbrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hdl/bbrs_datapath.sv]
`default_nettype none
module bbrs_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bbrs_pkg::dp_cmd_t  cmd,
  output bbrs_pkg::dp_stat_t      stat,
  input  wire logic [7:0]         red_in,
  input  wire logic [7:0]         green_in,
  input  wire logic [7:0]         blue_in,
  bbrs_out_if.source              out_px
);

  typedef enum logic [2:0] {E_IDLE, E_MUL, E_SAT, E_DIV, E_QUO, E_OUT} eng_t;

  localparam int STEP_W = $clog2(bbrs_pkg::WS_W);

  eng_t eng;

  logic [bbrs_pkg::PIX_W-1:0] pix [bbrs_pkg::NUM_CH];
  logic [bbrs_pkg::NUM_CH*bbrs_pkg::CS_W-1:0]  cs_rdata;
  logic [bbrs_pkg::NUM_CH*bbrs_pkg::CS_W-1:0]  cs_wdata;
  logic [bbrs_pkg::NUM_CH*bbrs_pkg::PIX_W-1:0] ls_rdata;
  logic [bbrs_pkg::NUM_CH*bbrs_pkg::PIX_W-1:0] ls_wdata;
  logic [bbrs_pkg::CS_W-1:0] cs_new [bbrs_pkg::NUM_CH];
  logic [bbrs_pkg::WS_W-1:0] ws [bbrs_pkg::NUM_CH];
  logic [bbrs_pkg::WS_W-1:0] ws_next [bbrs_pkg::NUM_CH];

  logic [bbrs_pkg::WS_W-1:0]    esum [bbrs_pkg::NUM_CH];
  logic [bbrs_pkg::PROD_W-1:0]  prod [bbrs_pkg::NUM_CH];
  logic [bbrs_pkg::WS_W-1:0]    dquo [bbrs_pkg::NUM_CH];
  logic [bbrs_pkg::CNT_W-1:0]   drem [bbrs_pkg::NUM_CH];
  logic [bbrs_pkg::WS_W-1:0]    dquo_next [bbrs_pkg::NUM_CH];
  logic [bbrs_pkg::CNT_W-1:0]   drem_next [bbrs_pkg::NUM_CH];
  logic [bbrs_pkg::PIX_W-1:0]   res [bbrs_pkg::NUM_CH];
  logic [bbrs_pkg::CNT_W-1:0]   ecnt;
  logic [bbrs_pkg::SCALE_W-1:0] escale;
  logic                         elast;
  logic                         eeoi;
  logic [STEP_W-1:0]            dstep;

  assign ls_wdata = {pix[2], pix[1], pix[0]};

  always_comb begin
    logic [bbrs_pkg::CS_W:0]    acc;
    logic [bbrs_pkg::PIX_W-1:0] sub;
    logic [bbrs_pkg::PIX_W-1:0] add;
    logic [bbrs_pkg::CS_W-1:0]  old;
    logic [bbrs_pkg::WS_W-1:0]  base;
    for (int c = 0; c < bbrs_pkg::NUM_CH; c++) begin
      old  = cs_rdata[c*bbrs_pkg::CS_W +: bbrs_pkg::CS_W];
      add  = cmd.drain ? '0 : pix[c];
      sub  = cmd.sub_en ? ls_rdata[c*bbrs_pkg::PIX_W +: bbrs_pkg::PIX_W] : '0;
      acc  = {1'b0, old} + (bbrs_pkg::CS_W+1)'(add);
      cs_new[c] = (acc >= (bbrs_pkg::CS_W+1)'(sub)) ?
                  bbrs_pkg::CS_W'(acc - (bbrs_pkg::CS_W+1)'(sub)) : '0;
      cs_wdata[c*bbrs_pkg::CS_W +: bbrs_pkg::CS_W] = cmd.clr ? '0 : cs_new[c];
      base = cmd.win_clr ? '0 : ws[c];
      ws_next[c] = ws[c];
      if (cmd.clr) begin
        ws_next[c] = '0;
      end else if (cmd.upd && cmd.win_en) begin
        ws_next[c] = base + bbrs_pkg::WS_W'(cs_new[c]);
      end else if (cmd.ws_sub) begin
        ws_next[c] = (ws[c] >= bbrs_pkg::WS_W'(old)) ? ws[c] - bbrs_pkg::WS_W'(old) : '0;
      end
    end
  end

  always_comb begin
    logic [bbrs_pkg::CNT_W:0] t;
    logic                     ge;
    for (int c = 0; c < bbrs_pkg::NUM_CH; c++) begin
      t  = {drem[c], dquo[c][bbrs_pkg::WS_W-1]};
      ge = (t >= {1'b0, ecnt});
      drem_next[c] = ge ? bbrs_pkg::CNT_W'(t - {1'b0, ecnt}) : bbrs_pkg::CNT_W'(t);
      dquo_next[c] = {dquo[c][bbrs_pkg::WS_W-2:0], ge};
    end
  end

  bbrs_ram #(
    .WIDTH(bbrs_pkg::NUM_CH * bbrs_pkg::CS_W),
    .DEPTH(bbrs_pkg::MAX_WIDTH)
  ) u_col_sums (
    .clk  (clk),
    .we   (cmd.upd | cmd.clr),
    .waddr(cmd.cs_waddr),
    .wdata(cs_wdata),
    .re   (cmd.rd),
    .raddr(cmd.cs_raddr),
    .rdata(cs_rdata)
  );

  bbrs_ram #(
    .WIDTH(bbrs_pkg::NUM_CH * bbrs_pkg::PIX_W),
    .DEPTH(bbrs_pkg::LS_DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (cmd.upd & ~cmd.drain),
    .waddr(cmd.ls_addr),
    .wdata(ls_wdata),
    .re   (cmd.rd),
    .raddr(cmd.ls_addr),
    .rdata(ls_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pix[0] <= red_in;
      pix[1] <= green_in;
      pix[2] <= blue_in;
    end
    if (rst) begin
      eng <= E_IDLE;
      for (int c = 0; c < bbrs_pkg::NUM_CH; c++) begin
        ws[c] <= '0;
      end
    end else begin
      for (int c = 0; c < bbrs_pkg::NUM_CH; c++) begin
        ws[c] <= ws_next[c];
      end
      case (eng)
        E_IDLE: begin
          if (cmd.emit) begin
            for (int c = 0; c < bbrs_pkg::NUM_CH; c++) begin
              esum[c] <= ws[c];
              dquo[c] <= ws[c];
              drem[c] <= '0;
            end
            ecnt   <= cmd.count;
            escale <= cmd.scale;
            elast  <= cmd.last;
            eeoi   <= cmd.eoi;
            dstep  <= '0;
            eng    <= cmd.approx ? E_MUL : E_DIV;
          end
        end
        E_MUL: begin
          for (int c = 0; c < bbrs_pkg::NUM_CH; c++) begin
            prod[c] <= bbrs_pkg::PROD_W'(esum[c]) * bbrs_pkg::PROD_W'(escale);
          end
          eng <= E_SAT;
        end
        E_SAT: begin
          for (int c = 0; c < bbrs_pkg::NUM_CH; c++) begin
            res[c] <= (prod[c][bbrs_pkg::PROD_W-1:bbrs_pkg::FRAC_BITS] >
                       (bbrs_pkg::PROD_W-bbrs_pkg::FRAC_BITS)'(bbrs_pkg::PIX_MAX)) ?
                      bbrs_pkg::PIX_MAX : prod[c][bbrs_pkg::FRAC_BITS +: bbrs_pkg::PIX_W];
          end
          eng <= E_OUT;
        end
        E_DIV: begin
          for (int c = 0; c < bbrs_pkg::NUM_CH; c++) begin
            dquo[c] <= dquo_next[c];
            drem[c] <= drem_next[c];
          end
          dstep <= dstep + 1'b1;
          if (dstep == STEP_W'(bbrs_pkg::WS_W - 1)) begin
            eng <= E_QUO;
          end
        end
        E_QUO: begin
          for (int c = 0; c < bbrs_pkg::NUM_CH; c++) begin
            if (ecnt == '0) begin
              res[c] <= '0;
            end else if (dquo[c] > bbrs_pkg::WS_W'(bbrs_pkg::PIX_MAX)) begin
              res[c] <= bbrs_pkg::PIX_MAX;
            end else begin
              res[c] <= dquo[c][bbrs_pkg::PIX_W-1:0];
            end
          end
          eng <= E_OUT;
        end
        E_OUT: begin
          if (out_px.ready) begin
            eng <= E_IDLE;
          end
        end
        default: eng <= E_IDLE;
      endcase
    end
  end

  assign stat.busy           = (eng != E_IDLE);
  assign out_px.valid        = (eng == E_OUT);
  assign out_px.red_out      = res[0];
  assign out_px.green_out    = res[1];
  assign out_px.blue_out     = res[2];
  assign out_px.alpha_out    = bbrs_pkg::PIX_MAX;
  assign out_px.last_in_run  = elast;
  assign out_px.end_of_image = eeoi;

endmodule
`default_nettype wire

[hdl/bbrs_ctrl.sv]
`default_nettype none
module bbrs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  bbrs_cfg_if.sink               cfg,
  input  wire logic              in_valid,
  input  wire logic              in_flush,
  output logic                   in_ready,
  output bbrs_pkg::dp_cmd_t      cmd,
  input  wire bbrs_pkg::dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_UPD, S_SUBK, S_MAIN, S_TRD, S_TSUB, S_TEMIT, S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  logic [bbrs_pkg::LW_W-1:0]   line_width;
  logic [bbrs_pkg::HGT_W-1:0]  image_height;
  logic [bbrs_pkg::RAD_W-1:0]  blur_radius;
  logic [bbrs_pkg::ROW_W-1:0]  row;
  logic [bbrs_pkg::COL_W-1:0]  col;
  logic [bbrs_pkg::SLOT_W-1:0] slot;
  logic [bbrs_pkg::TAIL_W-1:0] tail;
  logic [bbrs_pkg::COL_W-1:0]  clr_addr;

  logic [bbrs_pkg::COL_W:0]    w_eff;
  logic [bbrs_pkg::COL_W-1:0]  w_last;
  logic [bbrs_pkg::COL_W-1:0]  col_c;
  logic [bbrs_pkg::HGT_W-1:0]  h_eff;
  logic [bbrs_pkg::RAD_W-1:0]  r_eff;
  logic [bbrs_pkg::K_W-1:0]    k;
  logic [bbrs_pkg::ROW_W-1:0]  drain_d;
  logic                        drain;
  logic                        row_ge_k;
  logic                        row_ge_r;
  logic                        col_ge_k;
  logic                        last_col;
  logic                        end_img;
  logic                        has_tail;
  logic                        tail_last;
  logic                        tail_sub;
  logic [bbrs_pkg::K_W-1:0]    vcount;
  logic [bbrs_pkg::K_W-1:0]    hcount;
  logic [bbrs_pkg::K_W-1:0]    tcount;
  logic [bbrs_pkg::COL_W+1:0]  w_plus_j;

  assign w_eff = (line_width == '0) ? (bbrs_pkg::COL_W+1)'(1) :
                 (line_width > bbrs_pkg::MAX_WIDTH) ? (bbrs_pkg::COL_W+1)'(bbrs_pkg::MAX_WIDTH) :
                 (bbrs_pkg::COL_W+1)'(line_width);
  assign w_last = bbrs_pkg::COL_W'(w_eff - 1'b1);
  assign col_c  = ({1'b0, col} >= w_eff) ? w_last : col;
  assign h_eff  = (image_height == '0) ? bbrs_pkg::HGT_W'(1) : image_height;
  assign r_eff  = (blur_radius > bbrs_pkg::RADIUS_MAX) ?
                  bbrs_pkg::RAD_W'(bbrs_pkg::RADIUS_MAX) : blur_radius;
  assign k      = bbrs_pkg::K_W'(2 * r_eff + 1);

  assign drain    = (row >= bbrs_pkg::ROW_W'(h_eff));
  assign drain_d  = row - bbrs_pkg::ROW_W'(h_eff);
  assign row_ge_k = (row >= bbrs_pkg::ROW_W'(k));
  assign row_ge_r = (row >= bbrs_pkg::ROW_W'(r_eff));
  assign col_ge_k = (col_c >= k);
  assign last_col = (col_c == w_last);
  assign end_img  = last_col &&
                    ((row + 1'b1) >= (bbrs_pkg::ROW_W'(h_eff) + bbrs_pkg::ROW_W'(r_eff)));
  assign has_tail = last_col && (r_eff != '0);
  assign tail_last = (bbrs_pkg::RAD_W'(tail) == r_eff - 1'b1);
  assign w_plus_j = (bbrs_pkg::COL_W+2)'(w_eff) + (bbrs_pkg::COL_W+2)'(tail);
  assign tail_sub = (w_plus_j >= (bbrs_pkg::COL_W+2)'(k));

  always_comb begin
    if (drain) begin
      vcount = ((drain_d + 1'b1) >= bbrs_pkg::ROW_W'(k)) ? bbrs_pkg::K_W'(1) :
               bbrs_pkg::K_W'(k - 1'b1 - bbrs_pkg::K_W'(drain_d));
    end else begin
      vcount = row_ge_k ? k : bbrs_pkg::K_W'(row + 1'b1);
    end
    hcount = col_ge_k ? k : bbrs_pkg::K_W'(col_c + 1'b1);
    tcount = k - 1'b1 - bbrs_pkg::K_W'(tail);
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    cmd.ls_addr  = bbrs_pkg::LS_AW'(slot * bbrs_pkg::MAX_WIDTH + col_c);
    cmd.cs_waddr = col_c;
    cmd.cs_raddr = col_c;
    cmd.drain    = drain;
    cmd.scale    = bbrs_pkg::scale_for_radius(r_eff);
    case (state)
      S_CLEAR: begin
        cmd.clr      = 1'b1;
        cmd.cs_waddr = clr_addr;
        if (clr_addr == bbrs_pkg::COL_W'(bbrs_pkg::MAX_WIDTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (drain || !in_flush)) begin
          cmd.take   = 1'b1;
          cmd.rd     = 1'b1;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd     = 1'b1;
        cmd.sub_en  = row_ge_k;
        cmd.win_clr = (col_c == '0);
        cmd.win_en  = row_ge_r;
        if (!row_ge_r) begin
          state_next = S_DONE;
        end else if (col_ge_k) begin
          cmd.rd       = 1'b1;
          cmd.cs_raddr = col_c - bbrs_pkg::COL_W'(k);
          state_next   = S_SUBK;
        end else begin
          state_next = S_MAIN;
        end
      end
      S_SUBK: begin
        cmd.ws_sub = 1'b1;
        state_next = S_MAIN;
      end
      S_MAIN: begin
        if (col_c < r_eff) begin
          state_next = has_tail ? S_TRD : S_DONE;
        end else if (!stat.busy) begin
          cmd.emit   = 1'b1;
          cmd.approx = !drain && row_ge_k && col_ge_k;
          cmd.count  = bbrs_pkg::CNT_W'(vcount) * bbrs_pkg::CNT_W'(hcount);
          cmd.last   = !has_tail;
          cmd.eoi    = !has_tail && end_img;
          state_next = has_tail ? S_TRD : S_DONE;
        end
      end
      S_TRD: begin
        if (tail_sub) begin
          cmd.rd       = 1'b1;
          cmd.cs_raddr = bbrs_pkg::COL_W'(w_plus_j - (bbrs_pkg::COL_W+2)'(k));
          state_next   = S_TSUB;
        end else begin
          state_next = S_TEMIT;
        end
      end
      S_TSUB: begin
        cmd.ws_sub = 1'b1;
        state_next = S_TEMIT;
      end
      S_TEMIT: begin
        if (!stat.busy) begin
          cmd.emit   = 1'b1;
          cmd.count  = bbrs_pkg::CNT_W'(vcount) * bbrs_pkg::CNT_W'(tcount);
          cmd.last   = tail_last;
          cmd.eoi    = tail_last && end_img;
          state_next = tail_last ? S_DONE : S_TRD;
        end
      end
      S_DONE: begin
        state_next = end_img ? S_CLEAR : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      line_width   <= bbrs_pkg::LINE_WIDTH_RESET;
      image_height <= bbrs_pkg::IMAGE_HEIGHT_RESET;
      blur_radius  <= bbrs_pkg::BLUR_RADIUS_RESET;
      row          <= '0;
      col          <= '0;
      slot         <= '0;
      tail         <= '0;
      clr_addr     <= '0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (cfg.index)
          bbrs_pkg::REG_LINE_WIDTH:   line_width   <= cfg.data[bbrs_pkg::LW_W-1:0];
          bbrs_pkg::REG_IMAGE_HEIGHT: image_height <= cfg.data[bbrs_pkg::HGT_W-1:0];
          bbrs_pkg::REG_BLUR_RADIUS:  blur_radius  <= cfg.data[bbrs_pkg::RAD_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_CLEAR: clr_addr <= clr_addr + 1'b1;
        S_MAIN:  tail <= '0;
        S_TEMIT: begin
          if (!stat.busy && !tail_last) begin
            tail <= tail + 1'b1;
          end
        end
        S_DONE: begin
          if (last_col) begin
            col <= '0;
            if (end_img) begin
              row      <= '0;
              slot     <= '0;
              clr_addr <= '0;
            end else begin
              row  <= row + 1'b1;
              slot <= (bbrs_pkg::K_W'(slot) == k - 1'b1) ? '0 : slot + 1'b1;
            end
          end else begin
            col <= col_c + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/box_blur_rgb_stream.sv]
// Each pixel word passes take, column and window update, an optional leaving-column subtract
// and emit steps; exact-division results use a serial divider, full-window results a scale
// multiply, and a row end adds its r tail results. Results flow through a one-word output
// register, so the next word is taken while a result waits. The column-sum memory has one
// read port, so the leaving column is read in a step of its own. Reset is synchronous; after
// reset and after each image a clearing pass zeroes the 1024 column sums, during which no pixel word is taken.
`default_nettype none
module box_blur_rgb_stream (
  input wire logic   clk,
  input wire logic   rst,
  bbrs_in_if.sink    in_px,
  bbrs_out_if.source out_px,
  bbrs_cfg_if.sink   cfg
);

  bbrs_pkg::dp_cmd_t  cmd;
  bbrs_pkg::dp_stat_t stat;

  bbrs_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(in_px.valid),
    .in_flush(in_px.is_flush),
    .in_ready(in_px.ready),
    .cmd     (cmd),
    .stat    (stat)
  );

  bbrs_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .red_in  (in_px.red_in),
    .green_in(in_px.green_in),
    .blue_in (in_px.blue_in),
    .out_px  (out_px)
  );

endmodule
`default_nettype wire

[hdl/bbrs_check.sv]
`default_nettype none
module bbrs_check (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] alpha_out,
  input wire logic       last_in_run,
  input wire logic       end_of_image
);

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> alpha_out == 8'hFF)
    else $error("alpha is not opaque");

  a_eoi_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_image |-> last_in_run)
    else $error("end of image without end of run");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word shown after reset");

endmodule

bind box_blur_rgb_stream bbrs_check u_bbrs_check (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_px.valid),
  .out_ready   (out_px.ready),
  .alpha_out   (out_px.alpha_out),
  .last_in_run (out_px.last_in_run),
  .end_of_image(out_px.end_of_image)
);
`default_nettype wire

[verif/bbrs_blur_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module bbrs_blur_checker
  import bbrs_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  bbrs_in_if       in_px,
  bbrs_out_if      out_px,
  bbrs_cfg_if      cfg,
  output int       errors,
  output int       pending
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
    logic       eoi;
  } blur_word_t;

  int unsigned     cfg_w, cfg_h, cfg_r;
  int unsigned     row_pos, col_pos;
  logic [7:0]      line_px [KERNEL_MAX][MAX_WIDTH][NUM_CH];
  longint unsigned col_sum [MAX_WIDTH][NUM_CH];
  longint unsigned win_sum [NUM_CH];
  blur_word_t      blur_due[$];

  assign pending = blur_due.size();

  function automatic longint unsigned sat_sub(input longint unsigned a, b);
    return (a >= b) ? a - b : 0;
  endfunction

  function automatic blur_word_t blur_mean(input longint unsigned count, input bit approx,
                                           input longint unsigned scale);
    blur_word_t      wd;
    longint unsigned v [NUM_CH];
    for (int c = 0; c < NUM_CH; c++) begin
      if (approx) v[c] = (win_sum[c] * scale) >> FRAC_BITS;
      else v[c] = (count != 0) ? win_sum[c] / count : 0;
      if (v[c] > 255) v[c] = 255;
    end
    wd.red = v[0][7:0];
    wd.green = v[1][7:0];
    wd.blue = v[2][7:0];
    wd.alpha = PIX_MAX;
    wd.last = 1'b0;
    wd.eoi = 1'b0;
    return wd;
  endfunction

  task automatic clear_sums();
    for (int i = 0; i < MAX_WIDTH; i++)
      for (int c = 0; c < NUM_CH; c++) col_sum[i][c] = 0;
    for (int c = 0; c < NUM_CH; c++) win_sum[c] = 0;
  endtask

  task automatic blur_pixel(input logic [7:0] pr, pg, pb, input logic fl);
    int unsigned     w, h, r, k, row, col, slot, d, idx;
    longint unsigned scale, vcount, hcount, add, sub;
    bit              drain, approx;
    logic [7:0]      px [NUM_CH];
    blur_word_t      run[$];
    px[0] = pr;
    px[1] = pg;
    px[2] = pb;
    w = cfg_w;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = (cfg_h == 0) ? 1 : cfg_h;
    r = (cfg_r > RADIUS_MAX) ? RADIUS_MAX : cfg_r;
    k = 2 * r + 1;
    scale = (64'd1 << FRAC_BITS) / (k * k);
    row = row_pos;
    col = col_pos;
    if (col >= w) col = w - 1;
    drain = (row >= h);
    if (!drain && fl) return;
    slot = row % k;
    for (int c = 0; c < NUM_CH; c++) begin
      add = drain ? 0 : px[c];
      sub = (row >= k) ? line_px[slot][col][c] : 0;
      col_sum[col][c] = sat_sub(col_sum[col][c] + add, sub);
    end
    if (!drain)
      for (int c = 0; c < NUM_CH; c++) line_px[slot][col][c] = px[c];
    if (row >= r) begin
      if (drain) begin
        d = row - h;
        vcount = (d + 1 >= k) ? 1 : k - 1 - d;
      end else begin
        vcount = (row < k) ? row + 1 : k;
      end
      for (int c = 0; c < NUM_CH; c++) begin
        if (col == 0) win_sum[c] = 0;
        win_sum[c] += col_sum[col][c];
        if (col >= k) win_sum[c] = sat_sub(win_sum[c], col_sum[col - k][c]);
      end
      if (col >= r) begin
        hcount = (col < k) ? col + 1 : k;
        approx = !drain && row >= k && col >= k;
        run.push_back(blur_mean(vcount * hcount, approx, scale));
      end
      if (col == w - 1) begin
        for (int unsigned j = 0; j < r; j++) begin
          if (w + j >= k) begin
            idx = w + j - k;
            for (int c = 0; c < NUM_CH; c++) win_sum[c] = sat_sub(win_sum[c], col_sum[idx][c]);
          end
          run.push_back(blur_mean(vcount * (k - 1 - j), 1'b0, scale));
        end
      end
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    if (col == w - 1) begin
      col_pos = 0;
      if (row + 1 >= h + r) begin
        if (run.size() > 0) run[run.size() - 1].eoi = 1'b1;
        clear_sums();
        row_pos = 0;
      end else begin
        row_pos = row + 1;
      end
    end else begin
      col_pos = col + 1;
    end
    foreach (run[i]) blur_due.push_back(run[i]);
  endtask

  always @(posedge clk) begin
    blur_word_t seen, want;
    if (rst) begin
      cfg_w = LINE_WIDTH_RESET;
      cfg_h = IMAGE_HEIGHT_RESET;
      cfg_r = BLUR_RADIUS_RESET;
      row_pos = 0;
      col_pos = 0;
      clear_sums();
      blur_due.delete();
    end else begin
      if (out_px.valid && out_px.ready) begin
        seen = {out_px.red_out, out_px.green_out, out_px.blue_out, out_px.alpha_out,
                out_px.last_in_run, out_px.end_of_image};
        if (blur_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, actual %h", $time, seen);
        end else begin
          want = blur_due.pop_front();
          if (seen !== want) begin
            errors++;
            $display("%0t: mismatch, expected r=%h g=%h b=%h a=%h last=%b eoi=%b",
                     $time, want.red, want.green, want.blue, want.alpha, want.last, want.eoi);
            $display("%0t:           actual r=%h g=%h b=%h a=%h last=%b eoi=%b",
                     $time, seen.red, seen.green, seen.blue, seen.alpha, seen.last, seen.eoi);
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_LINE_WIDTH:   cfg_w = cfg.data[LW_W-1:0];
          REG_IMAGE_HEIGHT: cfg_h = cfg.data[HGT_W-1:0];
          REG_BLUR_RADIUS:  cfg_r = cfg.data[RAD_W-1:0];
          default: ;
        endcase
      end
      if (in_px.valid && in_px.ready)
        blur_pixel(in_px.red_in, in_px.green_in, in_px.blue_in, in_px.is_flush);
    end
  end

  initial errors = 0;

endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import bbrs_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 200;

  logic clk;
  logic rst;
  int   errors;
  int   pending;
  int   idle_cycles;
  bit   no_gaps;
  bit   long_hold;
  int   pixels_sent;

  bbrs_in_if  in_px();
  bbrs_out_if out_px();
  bbrs_cfg_if cfg();

  box_blur_rgb_stream u_top (.clk(clk), .rst(rst), .in_px(in_px), .out_px(out_px), .cfg(cfg));

  bbrs_blur_checker u_checker (.clk(clk), .rst(rst), .in_px(in_px), .out_px(out_px), .cfg(cfg),
                               .errors(errors), .pending(pending));

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (in_px.valid && in_px.ready) || (out_px.valid && out_px.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    out_px.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_px.ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = no_gaps ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_px.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_px.ready <= 1'b1;
      do @(posedge clk); while (!out_px.valid);
    end
  end

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return PIX_MAX;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic send_word(input logic [7:0] pr, pg, pb, input logic fl);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_px.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_px.valid <= 1'b1;
    in_px.red_in <= pr;
    in_px.green_in <= pg;
    in_px.blue_in <= pb;
    in_px.is_flush <= fl;
    do @(posedge clk); while (!in_px.ready);
    if (!fl) pixels_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    in_px.valid <= 1'b0;
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic settle();
    in_px.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_shape(input int unsigned w, h, r);
    settle();
    write_reg(REG_LINE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_BLUR_RADIUS, r);
    cfg.valid <= 1'b0;
  endtask

  // Random image: well-formed raster with occasional ignored flush words inside the
  // image and occasional pixel words among the drain slots.
  task automatic random_image(input int unsigned w, h, r);
    set_shape(w, h, r);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        if ($urandom_range(0, 11) == 0)
          send_word(8'($urandom()), 8'($urandom()), 8'($urandom()), 1'b1);
        send_word(pick_channel(), pick_channel(), pick_channel(), 1'b0);
      end
    for (int i = 0; i < r * w; i++)
      send_word(8'($urandom()), 8'($urandom()), 8'($urandom()), $urandom_range(0, 4) != 0);
  endtask

  initial begin
    int unsigned r, k;
    rst = 1'b1;
    no_gaps = 1'b0;
    long_hold = 1'b0;
    pixels_sent = 0;
    idle_cycles = 0;
    in_px.valid = 1'b0;
    in_px.red_in = '0;
    in_px.green_in = '0;
    in_px.blue_in = '0;
    in_px.is_flush = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_LINE_WIDTH;
    cfg.data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A 2x2 image with radius 0, a flush word inside the image, extreme channels.
    set_shape(2, 2, 0);
    send_word(8'h00, 8'h00, 8'h00, 1'b0);
    send_word(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_word(PIX_MAX, PIX_MAX, PIX_MAX, 1'b0);
    send_word(8'hFF, 8'h00, 8'h80, 1'b0);
    send_word(8'h01, 8'hFE, 8'h7F, 1'b0);

    // Radius 1 on a 3x3 image, with a pixel word and two flush words in the drain row.
    set_shape(3, 3, 1);
    for (int i = 0; i < 9; i++)
      send_word(pick_channel(), pick_channel(), pick_channel(), 1'b0);
    send_word(8'hAA, 8'h55, 8'hC3, 1'b0);
    send_word(8'h00, 8'h00, 8'h00, 1'b1);
    send_word(8'hFF, 8'hFF, 8'hFF, 1'b1);

    // Register extremes, then a large radius on a small image with a stalled receiver.
    settle();
    write_reg(REG_LINE_WIDTH, MAX_WIDTH);
    write_reg(REG_IMAGE_HEIGHT, 65535);
    write_reg(REG_BLUR_RADIUS, RADIUS_MAX);
    cfg.valid <= 1'b0;
    no_gaps = 1'b1;
    long_hold = 1'b1;
    random_image(10, 10, 4);
    no_gaps = 1'b0;

    while (pixels_sent < 190) begin
      r = $urandom_range(0, 3);
      k = 2 * r + 1;
      no_gaps = ($urandom_range(0, 3) == 0);
      random_image($urandom_range(k + 1, k + 5), $urandom_range(k + 1, k + 4), r);
    end
    no_gaps = 1'b0;

    settle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
hdl/bbrs_pkg.sv
hdl/bbrs_ifs.sv
hdl/bbrs_ram.sv
hdl/bbrs_datapath.sv
hdl/bbrs_ctrl.sv
hdl/box_blur_rgb_stream.sv
hdl/bbrs_check.sv
verif/bbrs_blur_checker.sv
verif/testbench.sv
